/* rtl/bvs_pkg.sv */
// ----------------------------------------------------------------------------
// bvs_pkg
// shared types, constants and the font table of the sprite bytecode core
// ----------------------------------------------------------------------------
`default_nettype none
package bvs_pkg;

  localparam int RamBytesDefault   = 4096;
  localparam int StackDepthDefault = 16;
  localparam int ScreenW           = 64;
  localparam int ScreenH           = 32;
  localparam int RegCount          = 16;
  localparam int FontBytes         = 80;
  localparam logic [11:0] FontBase = 12'h050;
  localparam logic [11:0] PcStart  = 12'h200;
  localparam logic [15:0] OpClear  = 16'h00E0;
  localparam logic [15:0] OpReturn = 16'h00EE;
  localparam logic [7:0]  SubAddI  = 8'h1E;
  localparam logic [7:0]  SubFont  = 8'h29;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_ROW   = 2'd2,
    CMD_CLRDF = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_UNIMP = 2'd1,
    FLT_OVER  = 2'd2,
    FLT_UNDER = 2'd3
  } fault_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FONT,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_RET_RD,
    ST_CLEAR,
    ST_SPR_RD,
    ST_SPR_ROW,
    ST_SPR_WR,
    ST_ROW_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [63:0] screen_row;
    logic        draw_flag;
    logic [7:0]  flag_register;
    logic [1:0]  fault;
  } result_t;

  function automatic logic [7:0] font_byte(input logic [6:0] i);
    logic [7:0] b;
    case (i)
      7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25, 7'd27,
      7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45, 7'd47,
      7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75, 7'd77:
        b = 8'hF0;
      7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51, 7'd53,
      7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68:
        b = 8'h90;
      7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
      7'd6:  b = 8'h60;
      7'd9:  b = 8'h70;
      7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
      7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
      7'd79:
        b = 8'h80;
      7'd38, 7'd39: b = 8'h40;
      7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/bvs_if.sv */
// ----------------------------------------------------------------------------
// bvs_in_if / bvs_out_if
// valid/ready channels of the sprite bytecode core
// ----------------------------------------------------------------------------
`default_nettype none
interface bvs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] addr;
  logic [7:0]  data;
  logic [7:0]  random_byte;
  modport source (output valid, op, addr, data, random_byte, input ready);
  modport sink   (input valid, op, addr, data, random_byte, output ready);
endinterface

interface bvs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pc_after;
  logic [63:0] screen_row;
  logic        draw_flag;
  logic [7:0]  flag_register;
  logic [1:0]  fault;
  modport source (output valid, pc_after, screen_row, draw_flag, flag_register,
                  fault, input ready);
  modport sink   (input valid, pc_after, screen_row, draw_flag, flag_register,
                  fault, output ready);
endinterface
`default_nettype wire

/* rtl/bvs_ram.sv */
// ----------------------------------------------------------------------------
// bvs_ram
// byte memory, one port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module bvs_ram #(
  parameter int RamBytes = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(RamBytes)-1:0] addr,
  input  wire logic [7:0]                  wdata,
  output logic [7:0]                       rdata
);
  logic [7:0] mem [RamBytes];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/bytecode_vm_sprite_core.sv */
// ----------------------------------------------------------------------------
// bytecode_vm_sprite_core
// sequenced bytecode interpreter with byte ram, screen memory and sprite draw
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   op, addr, data, random_byte
//  out_ch   out  pc_after, screen_row, draw_flag, flag_register, fault
//
//  one item at a time; a ram write or draw flag clear goes straight to the
//  result, a row read reads one screen row, an instruction is fetched and
//  decoded; return, clear screen and draw then run states of their own
//  after reset a sweep over all RamBytes addresses (4096 by default) clears
//  ram and screen and loads the font; no item meanwhile
//  the result waits in the output register until transferred; the next item
//  is taken in the cycle after that transfer at the earliest
`default_nettype none
module bytecode_vm_sprite_core #(
  parameter int RamBytes   = bvs_pkg::RamBytesDefault,
  parameter int StackDepth = bvs_pkg::StackDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  bvs_in_if.sink    in_ch,
  bvs_out_if.source out_ch
);
  import bvs_pkg::*;

  localparam int AW = $clog2(RamBytes);
  localparam int SW = $clog2(StackDepth);
  localparam int CW = $clog2(StackDepth + 1);

  state_t state, state_next;

  // latched item
  cmd_t        cmd;
  logic [11:0] iaddr;
  logic [7:0]  idata;
  logic [7:0]  rnd;

  // architectural state
  logic [7:0]  regs [RegCount];
  logic [11:0] index_reg;
  logic [11:0] pc;
  logic [11:0] stack [StackDepth];
  logic [CW-1:0] sp;
  logic        draw_pending;

  // screen memory: read then write back, one row at a time
  logic [63:0] screen [ScreenH];
  logic [63:0] scr_rdata;
  logic [4:0]  scr_addr;
  logic        scr_we;
  logic [63:0] scr_wdata;

  // sequencer work registers
  logic [7:0]  word_hi;
  logic [6:0]  cnt;
  logic [AW-1:0] sweep;
  logic [11:0] sweep_off;
  logic [3:0]  rows_left;
  logic [4:0]  row;
  logic [5:0]  xpos;
  logic [7:0]  bits;
  logic [11:0] ret_pc;
  logic [11:0] pc_dec;
  logic [1:0]  fault;
  result_t     res;
  logic        out_valid;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  bvs_ram #(.RamBytes(RamBytes)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // instruction word, valid in the decode cycle: low byte straight from ram
  logic [15:0] word;
  assign word = {word_hi, ram_rdata};

  // decode fields
  logic [3:0] top, rx, ry;
  logic [7:0] nn, vx, vy;
  assign top = word[15:12];
  assign rx  = word[11:8];
  assign ry  = word[7:4];
  assign nn  = word[7:0];
  assign vx  = regs[rx];
  assign vy  = regs[ry];

  // font window of the init sweep
  assign sweep_off = 12'(sweep) - FontBase;

  assign in_ch.ready = (state == ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.pc_after = res.pc_after;
  assign out_ch.screen_row = res.screen_row;
  assign out_ch.draw_flag = res.draw_flag;
  assign out_ch.flag_register = res.flag_register;
  assign out_ch.fault = res.fault;

  // sprite row: 8 bits placed at xpos, clipped at the right edge
  logic [71:0] spr_wide;
  logic [63:0] spr_mask;
  assign spr_wide = {bits, 64'd0} >> xpos;
  assign spr_mask = spr_wide[71:8];

  logic is_call, stack_full;
  assign stack_full = (sp == CW'(StackDepth));
  assign is_call = (top == 4'h2) || (top == 4'h0 && word != OpClear && word != OpReturn);

  // pc after decode; a return reloads it in the cycle after decode
  always_comb begin
    pc_dec = pc + 12'd2;
    if (is_call) begin
      if (!stack_full) pc_dec = word[11:0];
    end else begin
      case (top)
        4'h1: pc_dec = word[11:0];
        4'h3: if (vx == nn) pc_dec = pc + 12'd4;
        4'h4: if (vx != nn) pc_dec = pc + 12'd4;
        4'h5: if (vx == vy) pc_dec = pc + 12'd4;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          case (cmd_t'(in_ch.op))
            CMD_EXEC: state_next = ST_FETCH_HI;
            CMD_ROW:  state_next = ST_ROW_RD;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_FONT:     if (sweep == AW'(RamBytes - 1)) state_next = ST_IDLE;
      ST_FETCH_HI: state_next = ST_FETCH_LO;
      ST_FETCH_LO: state_next = ST_DECODE;
      ST_DECODE: begin
        if (word == OpClear) state_next = ST_CLEAR;
        else if (word == OpReturn && sp != '0) state_next = ST_RET_RD;
        else if (top == 4'hD) begin
          if (word[3:0] == 4'd0) state_next = ST_DONE;
          else state_next = ST_SPR_RD;
        end else state_next = ST_DONE;
      end
      ST_RET_RD:  state_next = ST_DONE;
      ST_CLEAR:   if (cnt == 7'(ScreenH - 1)) state_next = ST_DONE;
      ST_SPR_RD:  state_next = ST_SPR_ROW;
      ST_SPR_ROW: state_next = ST_SPR_WR;
      ST_SPR_WR: begin
        if (rows_left == 4'd1 || row == 5'(ScreenH - 1)) state_next = ST_DONE;
        else state_next = ST_SPR_RD;
      end
      ST_ROW_RD:  state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ram and screen port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(pc);
    ram_wdata = idata;
    scr_we    = 1'b0;
    scr_addr  = row;
    scr_wdata = scr_rdata ^ spr_mask;
    case (state)
      ST_IDLE: begin
        ram_we   = in_ch.valid && in_ch.ready && (cmd_t'(in_ch.op) == CMD_WRITE);
        ram_addr = AW'(in_ch.addr);
        ram_wdata = in_ch.data;
      end
      ST_FONT: begin
        // every ram byte zero except the glyphs; every screen row zero
        ram_we    = 1'b1;
        ram_addr  = sweep;
        ram_wdata = (sweep_off < 12'(FontBytes)) ? font_byte(sweep_off[6:0]) : 8'h00;
        scr_we    = 1'b1;
        scr_addr  = sweep[4:0];
        scr_wdata = '0;
      end
      ST_FETCH_HI: ram_addr = AW'(pc);
      ST_FETCH_LO: ram_addr = AW'(pc + 12'd1);
      ST_SPR_RD:   ram_addr = AW'(index_reg + 12'(cnt));
      ST_CLEAR: begin
        scr_we    = 1'b1;
        scr_addr  = cnt[4:0];
        scr_wdata = '0;
      end
      ST_SPR_WR:  scr_we = 1'b1;
      ST_ROW_RD:  scr_addr = iaddr[4:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      screen[scr_addr] <= scr_wdata;
    end
    scr_rdata <= screen[scr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FONT;
      cnt          <= '0;
      sweep        <= '0;
      out_valid    <= 1'b0;
      pc           <= PcStart;
      index_reg    <= '0;
      sp           <= '0;
      draw_pending <= 1'b0;
      for (int i = 0; i < RegCount; i++) regs[i] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd   <= cmd_t'(in_ch.op);
            iaddr <= in_ch.addr;
            idata <= in_ch.data;
            rnd   <= in_ch.random_byte;
            fault <= FLT_NONE;
            if (cmd_t'(in_ch.op) == CMD_CLRDF) draw_pending <= 1'b0;
          end
        end
        ST_FONT: sweep <= sweep + AW'(1);
        ST_FETCH_LO: word_hi <= ram_rdata;
        ST_DECODE: begin
          // first half of the word was latched last cycle; low byte arrives now
          cnt <= '0;
        end
        ST_RET_RD: pc <= ret_pc;
        ST_CLEAR: cnt <= cnt + 7'd1;
        ST_SPR_RD: ;
        ST_SPR_ROW: bits <= ram_rdata;
        ST_SPR_WR: begin
          if ((scr_rdata & spr_mask) != '0) regs[15] <= 8'd1;
          cnt       <= cnt + 7'd1;
          row       <= row + 5'd1;
          rows_left <= rows_left - 4'd1;
        end
        default: ;
      endcase

      // decode happens once the low byte is in
      if (state == ST_DECODE) begin
        pc <= pc_dec;
        case (top)
          4'h0, 4'h2: begin
            if (word == OpClear) begin
              draw_pending <= 1'b1;
            end else if (word == OpReturn) begin
              if (sp == '0) fault <= FLT_UNDER;
              else begin
                sp     <= sp - CW'(1);
                ret_pc <= stack[SW'(sp - CW'(1))];
              end
            end else if (is_call) begin
              if (stack_full) fault <= FLT_OVER;
              else begin
                stack[SW'(sp)] <= pc + 12'd2;
                sp <= sp + CW'(1);
              end
            end
          end
          4'h1, 4'h3, 4'h4, 4'h5: ;
          4'h6: regs[rx] <= nn;
          4'h7: regs[rx] <= vx + nn;
          4'hA: index_reg <= word[11:0];
          4'hC: regs[rx] <= rnd & nn;
          4'hD: begin
            regs[15]     <= 8'd0;
            draw_pending <= 1'b1;
            row          <= 5'(vy);
            xpos         <= 6'(vx);
            rows_left    <= word[3:0];
          end
          4'hF: begin
            if (nn == SubAddI) index_reg <= index_reg + 12'(vx);
            else if (nn == SubFont) index_reg <= FontBase + 12'(vx) * 12'd5;
            else fault <= FLT_UNIMP;
          end
          default: fault <= FLT_UNIMP;
        endcase
      end

      if (state == ST_DONE) begin
        out_valid <= 1'b1;
        res.pc_after        <= pc;
        res.screen_row      <= (cmd == CMD_ROW) ? scr_rdata : '0;
        res.draw_flag       <= draw_pending;
        res.flag_register   <= regs[15];
        res.fault           <= (cmd == CMD_EXEC) ? fault : FLT_NONE;
      end
    end
  end
endmodule
`default_nettype wire

/* sim/bytecode_vm_sprite_core_tb.sv */
// ----------------------------------------------------------------------------
// bytecode_vm_sprite_core_tb
// drives ram loads, instruction steps, screen row reads and draw flag clears
// into the sprite bytecode core, predicts every result with a behavioral
// model of the interpreter and compares each transfer field by field
// ----------------------------------------------------------------------------
module bytecode_vm_sprite_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bvs_pkg::*;

  // one input transfer
  typedef struct {
    cmd_t        op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  rnd;
  } vm_item_t;

  // directed row: item plus an optional typed-in expectation
  typedef struct {
    vm_item_t item;
    logic     has_exp;
    result_t  exp;
  } vm_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bvs_in_if  in_ch();
  bvs_out_if out_ch();

  bytecode_vm_sprite_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // interpreter shadow state
  // ---------------------------------------------------------------------------
  logic [7:0]  mem_shadow [RamBytesDefault];
  logic [63:0] pixels [ScreenH];
  logic [7:0]  vreg [RegCount];
  logic [11:0] index_shadow;
  logic [11:0] pc_shadow;
  logic [11:0] call_stack [StackDepthDefault];
  int          call_depth;
  logic        draw_shadow;

  result_t expected_results[$];
  int      errors = 0;
  int      idle_pct_in = 0;
  int      stall_pct_out = 0;
  longint  cycle_count = 0;

  task automatic reset_shadow();
    for (int i = 0; i < RamBytesDefault; i++) mem_shadow[i] = 8'h00;
    for (int i = 0; i < FontBytes; i++) mem_shadow[FontBase + i] = font_glyph(i);
    for (int i = 0; i < ScreenH; i++) pixels[i] = '0;
    for (int i = 0; i < RegCount; i++) vreg[i] = 8'h00;
    index_shadow = '0;
    pc_shadow = PcStart;
    call_depth = 0;
    draw_shadow = 1'b0;
  endtask

  // font glyphs, digits 0 to F, five rows each
  function automatic logic [7:0] font_glyph(int i);
    logic [7:0] glyphs [80];
    glyphs = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
               8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
               8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
               8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
               8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
               8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
               8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
               8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
    return glyphs[i];
  endfunction

  // call: overflow leaves pc past the call
  function automatic fault_t push_return(logic [11:0] target);
    if (call_depth >= StackDepthDefault) return FLT_OVER;
    call_stack[call_depth] = pc_shadow;
    call_depth++;
    pc_shadow = target;
    return FLT_NONE;
  endfunction

  // xor sprite draw, clipped at right and bottom edges, collision into vf
  function automatic void draw_sprite(logic [7:0] vx, logic [7:0] vy, logic [3:0] rows);
    int x, y, r, c;
    logic [7:0] bits;
    x = vx % ScreenW;
    y = vy % ScreenH;
    vreg[15] = 8'h00;
    for (int i = 0; i < rows; i++) begin
      r = y + i;
      if (r >= ScreenH) break;
      bits = mem_shadow[(index_shadow + i) % RamBytesDefault];
      for (int j = 0; j < 8; j++) begin
        c = x + j;
        if (c >= ScreenW || !bits[7 - j]) continue;
        if (pixels[r][63 - c]) vreg[15] = 8'h01;
        pixels[r][63 - c] ^= 1'b1;
      end
    end
    draw_shadow = 1'b1;
  endfunction

  function automatic fault_t run_instruction(logic [7:0] rnd);
    logic [15:0] word;
    logic [3:0]  rx, ry;
    logic [7:0]  nn;
    word = {mem_shadow[pc_shadow], mem_shadow[12'(pc_shadow + 1)]};
    rx = word[11:8];
    ry = word[7:4];
    nn = word[7:0];
    pc_shadow = pc_shadow + 12'd2;
    case (word[15:12])
      4'h0: begin
        if (word == OpClear) begin
          for (int i = 0; i < ScreenH; i++) pixels[i] = '0;
          draw_shadow = 1'b1;
        end else if (word == OpReturn) begin
          if (call_depth == 0) return FLT_UNDER;
          call_depth--;
          pc_shadow = call_stack[call_depth];
        end else begin
          return push_return(word[11:0]);
        end
      end
      4'h1: pc_shadow = word[11:0];
      4'h2: return push_return(word[11:0]);
      4'h3: if (vreg[rx] == nn) pc_shadow = pc_shadow + 12'd2;
      4'h4: if (vreg[rx] != nn) pc_shadow = pc_shadow + 12'd2;
      4'h5: if (vreg[rx] == vreg[ry]) pc_shadow = pc_shadow + 12'd2;
      4'h6: vreg[rx] = nn;
      4'h7: vreg[rx] = vreg[rx] + nn;
      4'hA: index_shadow = word[11:0];
      4'hC: vreg[rx] = rnd & nn;
      4'hD: draw_sprite(vreg[rx], vreg[ry], word[3:0]);
      4'hF: begin
        if (nn == SubAddI) index_shadow = index_shadow + 12'(vreg[rx]);
        else if (nn == SubFont) index_shadow = FontBase + 12'(vreg[rx] * 5);
        else return FLT_UNIMP;
      end
      default: return FLT_UNIMP;
    endcase
    return FLT_NONE;
  endfunction

  function automatic result_t predict_result(vm_item_t it);
    result_t res;
    res = '0;
    case (it.op)
      CMD_WRITE: mem_shadow[it.addr] = it.data;
      CMD_EXEC:  res.fault = run_instruction(it.rnd);
      CMD_ROW:   res.screen_row = pixels[it.addr[4:0]];
      default:   draw_shadow = 1'b0;
    endcase
    res.pc_after = pc_shadow;
    res.draw_flag = draw_shadow;
    res.flag_register = vreg[15];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pc_after, out_ch.screen_row, out_ch.draw_flag,
                out_ch.flag_register, out_ch.fault};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.pc_after !== want.pc_after)
            $display("%0t: pc expected %h actual %h", $realtime,
                     want.pc_after, got.pc_after);
          if (got.screen_row !== want.screen_row)
            $display("%0t: row expected %h actual %h", $realtime,
                     want.screen_row, got.screen_row);
          if (got.draw_flag !== want.draw_flag)
            $display("%0t: draw flag expected %b actual %b", $realtime,
                     want.draw_flag, got.draw_flag);
          if (got.flag_register !== want.flag_register)
            $display("%0t: vf expected %h actual %h", $realtime,
                     want.flag_register, got.flag_register);
          if (got.fault !== want.fault)
            $display("%0t: fault expected %0d actual %0d", $realtime,
                     want.fault, got.fault);
          if (got !== want) errors++;
        end
      end
    end
    // receiver backpressure
    out_ch.ready <= ($urandom_range(99) >= stall_pct_out);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // one transfer on the input channel, with random idle cycles ahead of it;
  // valid stays up into the next item when there is no idle cycle
  task automatic send_item(vm_item_t it, logic has_exp = 1'b0, result_t exp = '0);
    result_t pred;
    while ($urandom_range(99) < idle_pct_in) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.addr <= it.addr;
    in_ch.data <= it.data;
    in_ch.random_byte <= it.rnd;
    pred = predict_result(it);
    if (has_exp && pred !== exp) begin
      $display("%0t: table row expected %p model %p", $realtime, exp, pred);
      errors++;
    end
    expected_results.push_back(pred);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic vm_item_t mk(cmd_t op, logic [11:0] a, logic [7:0] d = 0,
                                  logic [7:0] r = 0);
    vm_item_t it;
    it = '{op, a, d, r};
    return it;
  endfunction

  // store an instruction word at pc and run it
  task automatic exec_word(logic [15:0] w, logic [7:0] r = 0);
    send_item(mk(CMD_WRITE, pc_shadow, w[15:8]));
    send_item(mk(CMD_WRITE, 12'(pc_shadow + 1), w[7:0]));
    send_item(mk(CMD_EXEC, 0, 0, r));
  endtask

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    int k;
    w = 16'($urandom);
    k = $urandom_range(99);
    if (k < 8) w = OpClear;
    else if (k < 16) w = OpReturn;
    else if (k < 24) w = {4'h2, w[11:0]};
    else if (k < 40) w = {4'hD, w[11:4], 4'($urandom_range(15))};
    else if (k < 50) w = {4'h6, w[11:0]};
    else if (k < 55) w = {4'hA, w[11:0]};
    else if (k < 60) w = {w[15:8], SubFont};
    else if (k < 64) w = {w[15:8], SubAddI};
    return w;
  endfunction

  vm_row_t dir_rows[$];

  initial begin
    int n, k;
    result_t e;
    in_ch.valid = 1'b0;
    in_ch.op = CMD_WRITE;
    in_ch.addr = '0;
    in_ch.data = '0;
    in_ch.random_byte = '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table: values after reset and the fault codes read off directly
    e = '{PcStart, 64'h0, 1'b0, 8'h00, FLT_NONE};
    dir_rows.push_back('{mk(CMD_ROW, 12'hFFF), 1'b1, e});
    dir_rows.push_back('{mk(CMD_CLRDF, 12'h000), 1'b1, e});
    dir_rows.push_back('{mk(CMD_WRITE, 12'hFFF, 8'hFF), 1'b1, e});
    // return on an empty stack: underflow
    dir_rows.push_back('{mk(CMD_WRITE, 12'h200, 8'h00), 1'b1, e});
    dir_rows.push_back('{mk(CMD_WRITE, 12'h201, 8'hEE), 1'b1, e});
    e.pc_after = 12'h202; e.fault = FLT_UNDER;
    dir_rows.push_back('{mk(CMD_EXEC, 0), 1'b1, e});
    // unimplemented alu group
    e.fault = FLT_NONE;
    dir_rows.push_back('{mk(CMD_WRITE, 12'h202, 8'h8A), 1'b1, e});
    dir_rows.push_back('{mk(CMD_WRITE, 12'h203, 8'hB4), 1'b1, e});
    e.pc_after = 12'h204; e.fault = FLT_UNIMP;
    dir_rows.push_back('{mk(CMD_EXEC, 0), 1'b1, e});
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);

    // predictor-checked directed cases
    exec_word(16'h6FFF);              // vf = ff
    exec_word(16'h7F01);              // add wraps, vf untouched by carry
    exec_word(16'h60FF); exec_word(16'h613F);
    exec_word(16'h6A1F); exec_word(16'h6B00);
    exec_word(16'hF029);              // font lookup with v0 = ff, index lands past the glyphs
    exec_word(16'hDAB5);              // draw five rows at x 31, y 0
    exec_word(16'hDAB5);              // redraw at the same place
    exec_word(16'hD010);              // n = 0
    exec_word(16'hC0A5, 8'h3C);
    exec_word(16'hF01E);
    exec_word(16'h30FF); exec_word(16'h4000); exec_word(16'h5017);
    send_item(mk(CMD_ROW, 12'h01F));
    exec_word(16'h00E0);
    // call overflow: fill the stack with calls to the next word
    for (int i = 0; i <= StackDepthDefault; i++)
      exec_word({4'h2, 12'(pc_shadow + 2)});
    for (int i = 0; i <= StackDepthDefault; i++) exec_word(OpReturn);
    exec_word(16'h1FFE);              // jump to the top, fetch wraps
    exec_word(16'hA000);
    exec_word(16'hFF65);

    // random part, several handshake phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1: begin idle_pct_in = 87; stall_pct_out = 0;  end
        2: begin idle_pct_in = 0;  stall_pct_out = 87; end
        3: begin idle_pct_in = 28; stall_pct_out = 28; end
        default: begin idle_pct_in = 0; stall_pct_out = 0; end
      endcase
      n = 0;
      while (n < 128) begin
        k = $urandom_range(99);
        if (k < 65) begin
          exec_word(random_word(), 8'($urandom));
          n += 3;
        end else if (k < 75) begin
          send_item(mk(CMD_EXEC, 0, 0, 8'($urandom)));
          n++;
        end else if (k < 85) begin
          send_item(mk(CMD_ROW, 12'($urandom)));
          n++;
        end else if (k < 90) begin
          send_item(mk(CMD_CLRDF, 12'($urandom), 8'($urandom)));
          n++;
        end else begin
          send_item(mk(CMD_WRITE, 12'($urandom), 8'($urandom)));
          n++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("bytecode_vm_sprite_core test passed");
    else
      $display("bytecode_vm_sprite_core test failed");
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > 600000) begin
      $display("bytecode_vm_sprite_core test failed");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/bvs_pkg.sv
rtl/bvs_if.sv
rtl/bvs_ram.sv
rtl/bytecode_vm_sprite_core.sv
sim/bytecode_vm_sprite_core_tb.sv
